/* rtl/hmp_pkg.sv */
// hmp_pkg: shared types, codes and helpers of the hash message padder
`default_nettype none

package hmp_pkg;

   // hash modes
   localparam logic [1:0] MODE_SHA256 = 2'd0;
   localparam logic [1:0] MODE_SHA512 = 2'd1;
   localparam logic [1:0] MODE_SHA3   = 2'd2;
   localparam logic [1:0] MODE_SHAKE  = 2'd3;

   // register indexes
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_HASH_MODE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE      = 1'd1;

   localparam logic [7:0] RATE_RESET = 8'd136;

   // padding bytes
   localparam logic [7:0] PAD_SHA   = 8'h80;
   localparam logic [7:0] PAD_SHA3  = 8'h06;
   localparam logic [7:0] PAD_SHAKE = 8'h1f;
   localparam logic [7:0] PAD_LAST  = 8'h80;

   // first byte position of the length field
   localparam logic [7:0] LEN_POS_SHA256 = 8'd56;
   localparam logic [7:0] LEN_POS_SHA512 = 8'd112;

   localparam logic [4:0] KECCAK_MIN_WORDS = 5'd9;
   localparam logic [4:0] KECCAK_MAX_WORDS = 5'd21;

   typedef struct packed {
      logic [63:0] data_word;
      logic [3:0]  valid_bytes;
      logic        last_item;
   } req_type;

   typedef struct packed {
      logic [63:0] out_word;
      logic        block_end;
      logic        message_end;
   } rsp_type;

   // context of the padding sequencer handed to the word former
   typedef struct packed {
      logic [1:0]  mode;
      logic [5:0]  g;
      logic        first;
      logic [7:0]  pos;
      logic [5:0]  total;
      logic [4:0]  wlast;
      logic [63:0] data;
      logic [63:0] len_lo;
      logic [63:0] len_hi;
   } hmp_ctx_type;

   // words per hash block for the mode and rate
   function automatic logic [4:0] blk_words(input logic [1:0] mode, input logic [7:0] rate);
      logic [4:0] w;
      begin
         w = rate[7:3];
         if (w < KECCAK_MIN_WORDS) w = KECCAK_MIN_WORDS;
         if (w > KECCAK_MAX_WORDS) w = KECCAK_MAX_WORDS;
         if (mode == MODE_SHA256) w = 5'd8;
         if (mode == MODE_SHA512) w = 5'd16;
         return w;
      end
   endfunction

endpackage

`default_nettype wire

/* rtl/hmp_word_gen.sv */
// hmp_word_gen: forms one padded word of the trailing padding sequence
`default_nettype none

module hmp_word_gen (
   input  wire hmp_pkg::hmp_ctx_type ctx,
   output hmp_pkg::rsp_type          word
);
   import hmp_pkg::*;

   logic [5:0]  g_last;
   logic [5:0]  g_prev;
   logic        is_last;
   logic        sha;
   logic [7:0]  pad_byte;
   logic [63:0] pad_word;
   logic [63:0] w_val;

   assign g_last  = ctx.total - 6'd1;
   assign g_prev  = ctx.total - 6'd2;
   assign is_last = (ctx.g == g_last);
   assign sha     = (ctx.mode == MODE_SHA256) || (ctx.mode == MODE_SHA512);

   always_comb begin
      case (ctx.mode)
         MODE_SHA3:  pad_byte = PAD_SHA3;
         MODE_SHAKE: pad_byte = PAD_SHAKE;
         default:    pad_byte = PAD_SHA;
      endcase
   end

   // pad byte lands at byte pos[2:0] counted from the top
   assign pad_word = {56'd0, pad_byte} << {~ctx.pos[2:0], 3'b000};

   always_comb begin
      w_val = ctx.first ? ctx.data : 64'd0;
      if (ctx.g == {1'b0, ctx.pos[7:3]}) w_val = w_val | pad_word;
      if (sha) begin
         if (is_last) w_val = ctx.len_lo;
         else if (ctx.mode == MODE_SHA512 && ctx.g == g_prev) w_val = ctx.len_hi;
      end else if (is_last) begin
         w_val = w_val | {56'd0, PAD_LAST};
      end
   end

   assign word.out_word    = w_val;
   assign word.block_end   = (ctx.g == {1'b0, ctx.wlast}) || is_last;
   assign word.message_end = is_last;

endmodule

`default_nettype wire

/* rtl/hash_message_padder.sv */
// hash_message_padder: sha-1/sha-2/sha-3/shake message padding on a 64-bit word stream
// a word that is not last is registered and leaves in the cycle after its beat is taken
// throughput: one non-last word per cycle while the output is not stalled; a last word holds
//   the input while the ST_LEN state folds the length carry and while the padding sequencer
//   forms its n padded words (up to 22), one word per cycle while the output is not stalled
// the input stalls while padding words are being produced and while the output is held
// reset (synchronous, active high) clears the length count and block position, sets
//   hash_mode to sha-1/sha-256 and keccak_rate_bytes to 136
`default_nettype none

module hash_message_padder (
   input  wire                                 clock,
   input  wire                                 reset,
   // message words
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire hmp_pkg::req_type               req_payload,
   // padded words
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output hmp_pkg::rsp_type                    rsp_payload,
   // register writes
   input  wire                                 csr_we,
   input  wire [hmp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire [hmp_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import hmp_pkg::*;

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;  // taking message words
   localparam logic [1:0] ST_LEN  = 2'd1;  // folding the last carry into the high count
   localparam logic [1:0] ST_PAD  = 2'd2;  // emitting padding words

   // registers
   logic [1:0]  state_ff, state_in;
   logic [1:0]  mode_ff, mode_in;
   logic [7:0]  rate_ff, rate_in;
   logic [63:0] cnt_lo_ff, cnt_lo_in;
   logic [60:0] cnt_hi_ff, cnt_hi_in;
   logic        carry_ff, carry_in;
   logic [4:0]  wib_ff, wib_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;
   // padding context
   logic [63:0] data_ff, data_in;
   logic [7:0]  pos_ff, pos_in;
   logic [5:0]  g_ff, g_in;
   logic [5:0]  total_ff, total_in;
   logic        first_ff, first_in;

   // combinational helpers
   logic        req_take;
   logic        out_free;
   logic [4:0]  w_c;
   logic [4:0]  wlast_c;
   logic [4:0]  wib_c;
   logic [3:0]  v_c;
   logic [64:0] lo_sum;
   logic [63:0] mask_c;
   logic [7:0]  pos_c;
   logic [7:0]  limit_c;
   logic        two_blk;
   hmp_ctx_type ctx;
   rsp_type     pad_word;

   // block geometry from the current mode and rate
   assign w_c     = blk_words(mode_ff, rate_ff);
   assign wlast_c = w_c - 5'd1;
   // an index left past the end by a mode change counts as the last word of the block
   assign wib_c   = (wib_ff > wlast_c) ? wlast_c : wib_ff;

   // valid count saturates at eight
   assign v_c = (req_payload.valid_bytes > 4'd8) ? 4'd8 : req_payload.valid_bytes;

   // output slot is free when empty or being drained this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign req_take  = req_valid && !req_stall;

   // a non-last beat always counts as eight bytes
   assign lo_sum = {1'b0, cnt_lo_ff}
                 + {61'd0, (req_payload.last_item ? v_c : 4'd8)};

   // keep only the leading valid bytes
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         mask_c[63-8*i -: 8] = (4'(i) < v_c) ? 8'hff : 8'h00;
      end
   end

   // first free byte after the data, counted from the block start
   assign pos_c = {wib_c, 3'b000} + {4'd0, v_c};

   // room needed at the block end: length field for sha, one byte for keccak
   always_comb begin
      unique case (mode_ff)
         MODE_SHA256: limit_c = LEN_POS_SHA256;
         MODE_SHA512: limit_c = LEN_POS_SHA512;
         default:     limit_c = {w_c, 3'b000};
      endcase
   end
   assign two_blk = (pos_c >= limit_c);

   // shared word former, stepped once per padding word
   assign ctx.mode   = mode_ff;
   assign ctx.g      = g_ff;
   assign ctx.first  = first_ff;
   assign ctx.pos    = pos_ff;
   assign ctx.total  = total_ff;
   assign ctx.wlast  = wlast_c;
   assign ctx.data   = data_ff;
   assign ctx.len_lo = {cnt_lo_ff[60:0], 3'b000};
   assign ctx.len_hi = {cnt_hi_ff, cnt_lo_ff[63:61]};

   hmp_word_gen u_word_gen (
      .ctx  (ctx),
      .word (pad_word)
   );

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      rate_in      = rate_ff;
      cnt_lo_in    = cnt_lo_ff;
      // carry from the previous add is registered and absorbed in the following cycle
      cnt_hi_in    = cnt_hi_ff + {60'd0, carry_ff};
      carry_in     = 1'b0;
      wib_in       = wib_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      data_in      = data_ff;
      pos_in       = pos_ff;
      g_in         = g_ff;
      total_in     = total_ff;
      first_in     = first_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_HASH_MODE: mode_in = csr_wdata[1:0];
            CSR_RATE:      rate_in = csr_wdata;
            default:       ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               cnt_lo_in = lo_sum[63:0];
               carry_in  = lo_sum[64];
               if (!req_payload.last_item) begin
                  // message word passes straight through
                  rsp_valid_in            = 1'b1;
                  rsp_data_in.out_word    = req_payload.data_word;
                  rsp_data_in.block_end   = (wib_c == wlast_c);
                  rsp_data_in.message_end = 1'b0;
                  wib_in = (wib_c == wlast_c) ? 5'd0 : wib_c + 5'd1;
               end else begin
                  // capture the tail and start the padding run
                  data_in  = req_payload.data_word & mask_c;
                  pos_in   = pos_c;
                  g_in     = {1'b0, wib_c};
                  first_in = 1'b1;
                  total_in = two_blk ? {w_c, 1'b0} : {1'b0, w_c};
                  state_in = ST_LEN;
               end
            end
         end
         ST_LEN: begin
            state_in = ST_PAD;
         end
         ST_PAD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pad_word;
               first_in     = 1'b0;
               if (pad_word.message_end) begin
                  // message done: ready for the next one
                  state_in  = ST_IDLE;
                  cnt_lo_in = 64'd0;
                  cnt_hi_in = 61'd0;
                  wib_in    = 5'd0;
               end else begin
                  g_in = g_ff + 6'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_SHA256;
         rate_ff      <= RATE_RESET;
         cnt_lo_ff    <= 64'd0;
         cnt_hi_ff    <= 61'd0;
         carry_ff     <= 1'b0;
         wib_ff       <= 5'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         rate_ff      <= rate_in;
         cnt_lo_ff    <= cnt_lo_in;
         cnt_hi_ff    <= cnt_hi_in;
         carry_ff     <= carry_in;
         wib_ff       <= wib_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and padding context carry no reset
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      data_ff     <= data_in;
      pos_ff      <= pos_in;
      g_ff        <= g_in;
      total_ff    <= total_in;
      first_ff    <= first_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // a beat is only taken while no padding run is active
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> (state_ff == ST_IDLE))
      else $error("input beat taken during padding");

   // the padding word index never runs past the message end
   a_g_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PAD) |-> (g_ff < total_ff))
      else $error("padding index past message end");

   // the high count has absorbed every carry once padding starts
   a_carry_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PAD) |-> !carry_ff)
      else $error("length carry pending during padding");

   // a message end word clears the length count
   a_cnt_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PAD && out_free && pad_word.message_end)
         |=> (cnt_lo_ff == 64'd0 && cnt_hi_ff == 61'd0 && wib_ff == 5'd0))
      else $error("length count not cleared after message end");

endmodule

`default_nettype wire
